FILE: hdl/otq_pkg.sv
package otq_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned ID_W     = 32;
  localparam int unsigned MAX_FIRE = 32;
  localparam int unsigned FIRE_W   = $clog2(MAX_FIRE);

  typedef enum logic [1:0] {
    ACT_ADD     = 2'd0,
    ACT_CANCEL  = 2'd1,
    ACT_ADVANCE = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_FULL      = 3'd1,
    ST_CANCELLED = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FIRED     = 3'd4,
    ST_NONE_DUE  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SWEEP,
    FSM_RESULT
  } fsm_e;

  // Ordering key: expiry in the upper half, so a plain compare gives (expiry, id) order.
  typedef struct packed {
    logic [TIME_W-1:0] expiry;
    logic [ID_W-1:0]   id;
  } key_t;

endpackage

FILE: hdl/ordered_timer_queue.sv
// Channel   Dir  Handshake                     Contents
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser: action; tdata: now, delay, cancel key
// m_axis    out  m_axis_tvalid/m_axis_tready   tuser: status; tdata: id, expiry, wait, empty
//
// Each request sweeps the table in RAM, one entry a cycle, then forms its result.
// Advance repeats the sweep for each timer it fires and gives one result per fired timer.
// Reset clears the valid bits and the id counter; the table is usable at once.
// A result waits in the output register while the next request is taken; a stalled
// output holds the block in its result cycle.
module ordered_timer_queue #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,

  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] now_ms, [63:32] delay_ms, [95:64] cancel_id, [127:96] cancel_expiry
  input  logic [127:0] s_axis_tdata,
  // [1:0] action
  input  logic [1:0]   s_axis_tuser,

  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] timer_id, [63:32] expiry, [95:64] next_wait_ms, [96] queue_empty, [103:97] zero
  output logic [103:0] m_axis_tdata,
  // [2:0] status
  output logic [2:0]   m_axis_tuser,
  output logic         m_axis_tlast
);

  import otq_pkg::*;

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  fsm_e                state_q, state_d;
  action_e             act_q, act_d;
  logic [TIME_W-1:0]   now_q, now_d;
  key_t                op_key_q, op_key_d;
  logic [ID_W-1:0]     id_ctr_q, id_ctr_d;
  logic [CAPACITY-1:0] valid_q, valid_d;

  logic [CNT_W-1:0]    iss_q, iss_d;
  logic                rd_vld_q, rd_vld_d;
  logic                rd_last_q, rd_last_d;
  logic [IDX_W-1:0]    rd_idx_q, rd_idx_d;

  logic                best_vld_q, best_vld_d;
  key_t                best_q, best_d;
  logic [IDX_W-1:0]    best_idx_q, best_idx_d;
  logic                sec_vld_q, sec_vld_d;
  key_t                sec_q, sec_d;
  logic                match_q, match_d;
  logic [IDX_W-1:0]    match_idx_q, match_idx_d;
  logic [FIRE_W-1:0]   fire_q, fire_d;

  logic                m_valid_q, m_valid_d;
  status_e             m_status_q, m_status_d;
  logic [ID_W-1:0]     m_id_q, m_id_d;
  logic [TIME_W-1:0]   m_exp_q, m_exp_d;
  logic [TIME_W-1:0]   m_wait_q, m_wait_d;
  logic                m_empty_q, m_empty_d;
  logic                m_last_q, m_last_d;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [IDX_W-1:0]    ram_raddr;
  logic [TIME_W-1:0]   exp_rdata;
  logic [ID_W-1:0]     id_rdata;
  key_t                rd_key;
  logic                rd_ok;
  logic                rd_match;
  logic                rd_take;

  logic [TIME_W:0]     exp_sum;
  logic [TIME_W-1:0]   exp_sat;
  logic [IDX_W-1:0]    free_slot;
  logic                table_full;
  key_t                add_min;
  logic                out_free;
  logic                fire_last;

  function automatic logic [TIME_W-1:0] wait_calc(input logic vld, input logic [TIME_W-1:0] e,
                                                  input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] w;
    w = '0;
    if (vld && (e > now)) begin
      w = e - now;
    end
    return w;
  endfunction

  otq_ram #(.WIDTH(TIME_W), .DEPTH(CAPACITY)) u_exp_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (op_key_q.expiry),
    .raddr_i (ram_raddr),
    .rdata_o (exp_rdata)
  );

  otq_ram #(.WIDTH(ID_W), .DEPTH(CAPACITY)) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (op_key_q.id),
    .raddr_i (ram_raddr),
    .rdata_o (id_rdata)
  );

  assign rd_key   = '{expiry: exp_rdata, id: id_rdata};
  assign rd_ok    = rd_vld_q && valid_q[rd_idx_q];
  assign rd_match = rd_key == op_key_q;
  // a cancelled entry must not count towards the remaining minimum
  assign rd_take  = rd_ok && !((act_q == ACT_CANCEL) && rd_match);

  assign exp_sum  = {1'b0, s_axis_tdata[31:0]} + {1'b0, s_axis_tdata[63:32]};
  assign exp_sat  = exp_sum[TIME_W] ? '1 : exp_sum[TIME_W-1:0];

  assign table_full = &valid_q;
  always_comb begin
    free_slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_slot = IDX_W'(i);
      end
    end
  end

  assign add_min   = (!match_q && (!best_vld_q || (op_key_q < best_q))) ? op_key_q : best_q;
  assign out_free  = !m_valid_q || m_axis_tready;
  assign fire_last = (fire_q == FIRE_W'(MAX_FIRE - 1)) || !sec_vld_q ||
                     (sec_q.expiry > now_q);

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    now_d       = now_q;
    op_key_d    = op_key_q;
    id_ctr_d    = id_ctr_q;
    valid_d     = valid_q;
    iss_d       = iss_q;
    rd_vld_d    = 1'b0;
    rd_last_d   = rd_last_q;
    rd_idx_d    = rd_idx_q;
    best_vld_d  = best_vld_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    sec_vld_d   = sec_vld_q;
    sec_d       = sec_q;
    match_d     = match_q;
    match_idx_d = match_idx_q;
    fire_d      = fire_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    m_status_d  = m_status_q;
    m_id_d      = m_id_q;
    m_exp_d     = m_exp_q;
    m_wait_d    = m_wait_q;
    m_empty_d   = m_empty_q;
    m_last_d    = m_last_q;
    ram_we      = 1'b0;
    ram_waddr   = free_slot;
    ram_raddr   = iss_q[IDX_W-1:0];
    s_axis_tready = 1'b0;

    // fold in the entry read last cycle
    if (rd_ok && rd_match) begin
      match_d     = 1'b1;
      match_idx_d = rd_idx_q;
    end
    if (rd_take) begin
      if (!best_vld_q || (rd_key < best_q)) begin
        sec_vld_d  = best_vld_q;
        sec_d      = best_q;
        best_vld_d = 1'b1;
        best_d     = rd_key;
        best_idx_d = rd_idx_q;
      end else if (!sec_vld_q || (rd_key < sec_q)) begin
        sec_vld_d = 1'b1;
        sec_d     = rd_key;
      end
    end

    unique case (state_q)
      FSM_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          act_d      = action_e'(s_axis_tuser);
          now_d      = s_axis_tdata[31:0];
          if (action_e'(s_axis_tuser) == ACT_ADD) begin
            op_key_d = '{expiry: exp_sat, id: id_ctr_q + ID_W'(1)};
          end else begin
            op_key_d = '{expiry: s_axis_tdata[127:96], id: s_axis_tdata[95:64]};
          end
          iss_d      = '0;
          best_vld_d = 1'b0;
          sec_vld_d  = 1'b0;
          match_d    = 1'b0;
          fire_d     = '0;
          state_d    = FSM_SWEEP;
        end
      end
      FSM_SWEEP: begin
        if (iss_q < CNT_W'(CAPACITY)) begin
          rd_vld_d  = 1'b1;
          rd_idx_d  = iss_q[IDX_W-1:0];
          rd_last_d = iss_q == CNT_W'(CAPACITY - 1);
          iss_d     = iss_q + CNT_W'(1);
        end
        if (rd_vld_q && rd_last_q) begin
          state_d = FSM_RESULT;
        end
      end
      FSM_RESULT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_last_d  = 1'b1;
          state_d   = FSM_IDLE;
          case (act_q)
            ACT_ADD: begin
              m_exp_d = op_key_q.expiry;
              if (table_full) begin
                m_status_d = ST_FULL;
                m_id_d     = '0;
                m_wait_d   = wait_calc(best_vld_q, best_q.expiry, now_q);
                m_empty_d  = !best_vld_q;
              end else begin
                m_status_d = ST_ADDED;
                m_id_d     = op_key_q.id;
                m_wait_d   = wait_calc(1'b1, add_min.expiry, now_q);
                m_empty_d  = 1'b0;
                id_ctr_d   = op_key_q.id;
                // an equal key only appears after the ids wrap: keep the one copy
                if (!match_q) begin
                  ram_we             = 1'b1;
                  valid_d[free_slot] = 1'b1;
                end
              end
            end
            ACT_CANCEL: begin
              m_status_d = match_q ? ST_CANCELLED : ST_NOT_FOUND;
              m_id_d     = op_key_q.id;
              m_exp_d    = op_key_q.expiry;
              m_wait_d   = wait_calc(best_vld_q, best_q.expiry, now_q);
              m_empty_d  = !best_vld_q;
              if (match_q) begin
                valid_d[match_idx_q] = 1'b0;
              end
            end
            ACT_ADVANCE: begin
              if (best_vld_q && (best_q.expiry <= now_q)) begin
                m_status_d          = ST_FIRED;
                m_id_d              = best_q.id;
                m_exp_d             = best_q.expiry;
                m_wait_d            = wait_calc(sec_vld_q, sec_q.expiry, now_q);
                m_empty_d           = !sec_vld_q;
                m_last_d            = fire_last;
                valid_d[best_idx_q] = 1'b0;
                if (!fire_last) begin
                  iss_d      = '0;
                  best_vld_d = 1'b0;
                  sec_vld_d  = 1'b0;
                  fire_d     = fire_q + FIRE_W'(1);
                  state_d    = FSM_SWEEP;
                end
              end else begin
                m_status_d = ST_NONE_DUE;
                m_id_d     = '0;
                m_exp_d    = '0;
                m_wait_d   = wait_calc(best_vld_q, best_q.expiry, now_q);
                m_empty_d  = !best_vld_q;
              end
            end
            default: begin
              m_status_d = ST_NONE_DUE;
              m_id_d     = '0;
              m_exp_d    = '0;
              m_wait_d   = wait_calc(best_vld_q, best_q.expiry, now_q);
              m_empty_d  = !best_vld_q;
            end
          endcase
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FSM_IDLE;
      id_ctr_q  <= '0;
      valid_q   <= '0;
      rd_vld_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      id_ctr_q  <= id_ctr_d;
      valid_q   <= valid_d;
      rd_vld_q  <= rd_vld_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q       <= act_d;
    now_q       <= now_d;
    op_key_q    <= op_key_d;
    iss_q       <= iss_d;
    rd_last_q   <= rd_last_d;
    rd_idx_q    <= rd_idx_d;
    best_vld_q  <= best_vld_d;
    best_q      <= best_d;
    best_idx_q  <= best_idx_d;
    sec_vld_q   <= sec_vld_d;
    sec_q       <= sec_d;
    match_q     <= match_d;
    match_idx_q <= match_idx_d;
    fire_q      <= fire_d;
    m_status_q  <= m_status_d;
    m_id_q      <= m_id_d;
    m_exp_q     <= m_exp_d;
    m_wait_q    <= m_wait_d;
    m_empty_q   <= m_empty_d;
    m_last_q    <= m_last_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tdata  = {7'b0, m_empty_q, m_wait_q, m_exp_q, m_id_q};

endmodule

FILE: hdl/otq_ram.sv
module otq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
